// ----- rtl/csvp_pkg.sv -----
// ----------------------------------------------------------------------------
// CSV parser package
// Shared constants, command entry type and the strtoul digit step used by the
// CSV record field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package csvp_pkg;

   localparam int MAX_FIELDS   = 32;
   localparam int COL_W        = 6;
   localparam int IDX_W        = 5;
   localparam int ACC_W        = 64;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   // Field parse phases.
   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_NUM    = 3'd1;
   localparam logic [2:0] PH_QNUM   = 3'd2;
   localparam logic [2:0] PH_QNUM_Q = 3'd3;
   localparam logic [2:0] PH_STR    = 3'd4;
   localparam logic [2:0] PH_STR_Q  = 3'd5;

   // Number scan phases.
   localparam logic [1:0] NP_WS     = 2'd0;
   localparam logic [1:0] NP_SIGN   = 2'd1;
   localparam logic [1:0] NP_DIGITS = 2'd2;
   localparam logic [1:0] NP_DONE   = 2'd3;

   // Characters.
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   // Configuration register indexes.
   localparam logic [7:0] CSR_FIELD_COUNT = 8'd0;
   localparam logic [7:0] CSR_STRING_MASK = 8'd1;

   // Largest accumulator value that can still take one more digit.
   localparam logic [ACC_W-1:0] ACC_LIMIT = 64'd1844674407370955161;

   typedef struct packed {
      logic [1:0]       nphase;
      logic [ACC_W-1:0] acc;
      logic             ovf;
      logic             neg;
   } num_state_type;

   localparam num_state_type NUM_CLEAR = '{nphase: NP_WS, acc: '0, ovf: 1'b0, neg: 1'b0};

   // One queue entry: every result that a single input transaction causes.
   // Order of issue is text byte, field word, then zero fill.
   typedef struct packed {
      logic             text_en;
      logic [7:0]       text_val;
      logic             word_en;
      logic [31:0]      word_val;
      logic [COL_W-1:0] col;
      logic             fill_en;
      logic [COL_W-1:0] cnt;
   } cmd_type;

   // One byte of a base-10 strtoul scan.
   function automatic num_state_type feed_number(num_state_type s, logic [7:0] b);
      num_state_type r;
      logic          digit;
      logic          space;
      logic [3:0]    d;
      r     = s;
      digit = (b >= CH_ZERO) && (b <= CH_NINE);
      space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
      d     = b[3:0];
      case (s.nphase)
         NP_WS: begin
            if (!space) begin
               if ((b == CH_PLUS) || (b == CH_MINUS)) begin
                  r.neg    = (b == CH_MINUS);
                  r.nphase = NP_SIGN;
               end else begin
                  r.nphase = digit ? NP_DIGITS : NP_DONE;
               end
            end
         end
         NP_SIGN: begin
            r.nphase = digit ? NP_DIGITS : NP_DONE;
         end
         NP_DIGITS: begin
            if (!digit) r.nphase = NP_DONE;
         end
         default: begin
            r.nphase = NP_DONE;
         end
      endcase
      if ((r.nphase == NP_DIGITS) && (s.nphase != NP_WS || !space) && !s.ovf) begin
         if ((s.acc > ACC_LIMIT) || ((s.acc == ACC_LIMIT) && (d > 4'd5))) begin
            r.ovf = 1'b1;
         end else begin
            r.acc = (s.acc << 3) + (s.acc << 1) + {{(ACC_W-4){1'b0}}, d};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/csvp_if.sv -----
// ----------------------------------------------------------------------------
// CSV parser channel interfaces
// Valid/ready channels for input bytes, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface csvp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_data;
   modport source (output valid, output data_byte, output end_of_data, input ready);
   modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface csvp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [4:0]  field_index;
   logic [31:0] word_value;
   logic [7:0]  text_byte;
   logic        row_end;
   logic        last;
   modport source (output valid, output kind, output field_index, output word_value,
                   output text_byte, output row_end, output last, input ready);
   modport sink   (input valid, input kind, input field_index, input word_value,
                   input text_byte, input row_end, input last, output ready);
endinterface

interface csvp_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/csvp_front.sv -----
// ----------------------------------------------------------------------------
// CSV parser front end
// Accepts one byte per cycle while the command queue is not full, tracks field and
// number state, and turns each byte into at most one command entry for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module csvp_front (
   input  logic                      clock,
   input  logic                      reset,
   csvp_req_if.sink                  req_if,
   input  logic [5:0]                field_count,
   input  logic [31:0]               string_column_mask,
   input  logic                      queue_full,
   output logic                      push,
   output csvp_pkg::cmd_type         push_cmd
);
   import csvp_pkg::*;

   logic [2:0]       phase_ff,        phase_in;
   logic [COL_W-1:0] column_ff,       column_in;
   logic             line_started_ff, line_started_in;
   num_state_type    num_ff,          num_in;
   logic [31:0]      blk_len_ff,      blk_len_in;
   logic [31:0]      str_start_ff,    str_start_in;
   logic             str_nonempty_ff, str_nonempty_in;

   logic             accept;
   logic [7:0]       b;
   logic             is_line_end;
   logic [COL_W-1:0] eff_cnt;
   logic             is_str_phase;
   logic             fin_term;
   logic [31:0]      fin_val;
   num_state_type    feed_cur;
   num_state_type    feed_clr;
   logic             line_fin;
   logic [COL_W-1:0] fill_from;
   logic             finish_cur;
   logic             start_after;
   logic             start_now;
   logic             str_byte;
   logic [COL_W-1:0] scol;
   logic             scol_is_str;
   cmd_type          cmd;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && !queue_full;
   assign b            = req_if.data_byte;
   assign is_line_end  = req_if.end_of_data || (b == CH_NEWLINE);

   assign eff_cnt = (field_count == '0) ? COL_W'(1) :
                    (field_count > COL_W'(MAX_FIELDS)) ? COL_W'(MAX_FIELDS) : field_count;

   assign is_str_phase = (phase_ff == PH_STR) || (phase_ff == PH_STR_Q);
   assign fin_term     = is_str_phase && str_nonempty_ff;
   assign fin_val      = is_str_phase ? (str_nonempty_ff ? str_start_ff : 32'd0) :
                         num_ff.ovf   ? 32'd0 :
                         num_ff.neg   ? (32'd0 - num_ff.acc[31:0]) : num_ff.acc[31:0];

   assign feed_cur = feed_number(num_ff, b);
   assign feed_clr = feed_number(NUM_CLEAR, b);

   assign line_fin  = line_started_ff && (phase_ff != PH_START) && (column_ff < eff_cnt);
   assign fill_from = line_fin ? (column_ff + COL_W'(1)) : column_ff;

   // A field that starts right after a closing quote lands in the next column.
   assign scol        = ((phase_ff == PH_QNUM_Q) || (phase_ff == PH_STR_Q)) ?
                        (column_ff + COL_W'(1)) : column_ff;
   assign scol_is_str = (scol != '0) && !scol[COL_W-1] && string_column_mask[scol[IDX_W-1:0]];

   always_comb begin
      phase_in        = phase_ff;
      column_in       = column_ff;
      line_started_in = line_started_ff;
      num_in          = num_ff;
      blk_len_in      = blk_len_ff;
      str_start_in    = str_start_ff;
      str_nonempty_in = str_nonempty_ff;
      cmd             = '0;
      cmd.col         = column_ff;
      cmd.cnt         = eff_cnt;
      finish_cur      = 1'b0;
      start_after     = 1'b0;
      start_now       = 1'b0;
      str_byte        = 1'b0;

      if (accept) begin
         if (is_line_end) begin
            finish_cur  = line_fin;
            cmd.fill_en = line_started_ff && (fill_from < eff_cnt);
         end else begin
            line_started_in = 1'b1;
            case (phase_ff)
               PH_NUM: begin
                  if (b == CH_COMMA) finish_cur = 1'b1;
                  else num_in = feed_cur;
               end
               PH_QNUM: begin
                  if (b == CH_QUOTE) phase_in = PH_QNUM_Q;
                  else num_in = feed_cur;
               end
               PH_QNUM_Q: begin
                  if (b == CH_QUOTE) begin
                     num_in   = feed_cur;
                     phase_in = PH_QNUM;
                  end else begin
                     finish_cur  = 1'b1;
                     start_after = (b != CH_COMMA);
                  end
               end
               PH_STR: begin
                  if (b == CH_QUOTE) phase_in = PH_STR_Q;
                  else str_byte = 1'b1;
               end
               PH_STR_Q: begin
                  if (b == CH_QUOTE) begin
                     str_byte = 1'b1;
                     phase_in = PH_STR;
                  end else begin
                     finish_cur  = 1'b1;
                     start_after = (b != CH_COMMA);
                  end
               end
               default: begin
                  start_now = 1'b1;
               end
            endcase
         end
      end

      if (str_byte) begin
         if (!str_nonempty_ff) begin
            str_nonempty_in = 1'b1;
            str_start_in    = blk_len_ff;
         end
         cmd.text_en  = 1'b1;
         cmd.text_val = b;
         blk_len_in   = blk_len_ff + 32'd1;
      end

      if (finish_cur) begin
         cmd.text_en     = fin_term;
         cmd.text_val    = '0;
         cmd.word_en     = 1'b1;
         cmd.word_val    = fin_val;
         blk_len_in      = blk_len_ff + {31'd0, fin_term};
         column_in       = column_ff + COL_W'(1);
         phase_in        = PH_START;
         num_in          = NUM_CLEAR;
         str_start_in    = '0;
         str_nonempty_in = 1'b0;
      end

      if ((start_after || start_now) && (scol < eff_cnt)) begin
         if (b == CH_QUOTE) begin
            phase_in = scol_is_str ? PH_STR : PH_QNUM;
         end else if (b == CH_COMMA) begin
            // A bare comma closes an empty numeric field.
            cmd.word_en  = 1'b1;
            cmd.word_val = '0;
            column_in    = scol + COL_W'(1);
         end else begin
            phase_in = PH_NUM;
            num_in   = feed_clr;
         end
      end

      if (accept && is_line_end) begin
         phase_in        = PH_START;
         num_in          = NUM_CLEAR;
         str_start_in    = '0;
         str_nonempty_in = 1'b0;
         column_in       = '0;
         line_started_in = 1'b0;
         if (req_if.end_of_data) blk_len_in = 32'd1;
      end
   end

   assign push     = accept && (cmd.text_en || cmd.word_en || cmd.fill_en);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         column_ff       <= '0;
         line_started_ff <= 1'b0;
         num_ff          <= NUM_CLEAR;
         blk_len_ff      <= 32'd1;
         str_start_ff    <= '0;
         str_nonempty_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         column_ff       <= column_in;
         line_started_ff <= line_started_in;
         num_ff          <= num_in;
         blk_len_ff      <= blk_len_in;
         str_start_ff    <= str_start_in;
         str_nonempty_ff <= str_nonempty_in;
      end
   end

   a_column_needs_line: assert property (@(posedge clock) disable iff (reset)
      (column_ff != '0) |-> line_started_ff)
      else $error("column advanced without a started line");

   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      column_ff <= COL_W'(MAX_FIELDS))
      else $error("column index beyond the field limit");

endmodule

`default_nettype wire

// ----- rtl/csvp_queue.sv -----
// ----------------------------------------------------------------------------
// CSV parser command queue
// Small first-in first-out buffer of command entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module csvp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  csvp_pkg::cmd_type push_cmd,
   input  logic              pop,
   output csvp_pkg::cmd_type head,
   output logic              full,
   output logic              empty
);
   import csvp_pkg::*;

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_ff + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("command queue written while full");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command queue read while empty");

endmodule

`default_nettype wire

// ----- rtl/csvp_back.sv -----
// ----------------------------------------------------------------------------
// CSV parser back end
// Expands the head command into result transactions, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module csvp_back (
   input  logic              clock,
   input  logic              reset,
   input  csvp_pkg::cmd_type head,
   input  logic              empty,
   output logic              pop,
   csvp_rsp_if.source        rsp_if
);
   import csvp_pkg::*;

   localparam logic [1:0] SUB_TEXT = 2'd0;
   localparam logic [1:0] SUB_WORD = 2'd1;
   localparam logic [1:0] SUB_FILL = 2'd2;

   logic             started_ff;
   logic [1:0]       sub_ff;
   logic [COL_W-1:0] fill_col_ff;

   logic             rsp_valid_ff;
   logic             rsp_kind_ff;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic [31:0]      rsp_word_ff;
   logic [7:0]       rsp_text_ff;
   logic             rsp_row_end_ff;
   logic             rsp_last_ff;

   logic             advance;
   logic [COL_W-1:0] fill_first;
   logic [1:0]       first_sub;
   logic [1:0]       sub;
   logic [COL_W-1:0] fcol;
   logic [COL_W-1:0] fcol_next;
   logic [1:0]       sub_in;
   logic             done;
   logic             res_kind;
   logic [IDX_W-1:0] res_idx;
   logic [31:0]      res_word;
   logic [7:0]       res_text;
   logic             res_row_end;

   assign advance    = !empty && (!rsp_valid_ff || rsp_if.ready);
   assign fill_first = head.word_en ? (head.col + COL_W'(1)) : head.col;
   assign first_sub  = head.text_en ? SUB_TEXT : (head.word_en ? SUB_WORD : SUB_FILL);
   assign sub        = started_ff ? sub_ff : first_sub;
   assign fcol       = started_ff ? fill_col_ff : fill_first;
   assign fcol_next  = fcol + COL_W'(1);

   always_comb begin
      res_kind    = 1'b0;
      res_idx     = head.col[IDX_W-1:0];
      res_word    = '0;
      res_text    = '0;
      res_row_end = 1'b0;
      sub_in      = SUB_FILL;
      done        = 1'b0;
      case (sub)
         SUB_TEXT: begin
            res_kind = 1'b1;
            res_text = head.text_val;
            if (head.word_en) sub_in = SUB_WORD;
            else done = !head.fill_en;
         end
         SUB_WORD: begin
            res_word    = head.word_val;
            res_row_end = ((head.col + COL_W'(1)) == head.cnt);
            done        = !head.fill_en;
         end
         default: begin
            res_idx     = fcol[IDX_W-1:0];
            res_row_end = (fcol_next == head.cnt);
            done        = !(fcol_next < head.cnt);
         end
      endcase
   end

   assign pop = advance && done;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         sub_ff       <= SUB_TEXT;
         fill_col_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         started_ff   <= !done;
         sub_ff       <= sub_in;
         fill_col_ff  <= (sub == SUB_FILL) ? fcol_next : fill_first;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_kind_ff    <= res_kind;
         rsp_idx_ff     <= res_idx;
         rsp_word_ff    <= res_word;
         rsp_text_ff    <= res_text;
         rsp_row_end_ff <= res_row_end;
         rsp_last_ff    <= done;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.kind        = rsp_kind_ff;
   assign rsp_if.field_index = rsp_idx_ff;
   assign rsp_if.word_value  = rsp_word_ff;
   assign rsp_if.text_byte   = rsp_text_ff;
   assign rsp_if.row_end     = rsp_row_end_ff;
   assign rsp_if.last        = rsp_last_ff;

   a_text_fields_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff) |-> (!rsp_row_end_ff && (rsp_word_ff == '0)))
      else $error("string byte result carries word fields");

   a_head_held: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> !empty)
      else $error("partly issued command left the queue");

endmodule

`default_nettype wire

// ----- rtl/csv_record_field_parser.sv -----
// ----------------------------------------------------------------------------
// CSV record field parser
// Parses CSV row text byte by byte into record field words and string block
// bytes, with numeric fields read as base-10 64-bit values.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Transaction contents
//   -------  ---  ------------------------------------------------------------
//   req_if   in   data_byte, end_of_data
//   rsp_if   out  kind, field_index, word_value, text_byte, row_end, last
//   csr_if   in   index (0 field_count, 1 string_column_mask), data
//
// One input transaction is taken per cycle while the command queue is not full;
// the front end does all per-byte parsing, including the 64-bit digit step,
// combinationally as the byte is accepted. The back end issues one result per
// cycle while rsp_if is not stalled, into a registered output stage, so the
// first result of an input passes through the command queue and then the
// output register before it is presented. A line end that has to zero-fill
// the row issues up to 32 results; the four-entry command queue absorbs input
// meanwhile and req_if.ready drops only when it is full.
// Reset is synchronous and returns configuration and parse state to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_record_field_parser (
   input  logic        clock,
   input  logic        reset,
   csvp_req_if.sink    req_if,
   csvp_rsp_if.source  rsp_if,
   csvp_csr_if.sink    csr_if
);
   import csvp_pkg::*;

   // Configuration registers. Writes are always taken; software must keep the block
   // idle whenever it changes them (the block does not enforce this), and they feed the front end directly.
   logic [5:0]  field_count_ff;
   logic [31:0] string_mask_ff;

   logic        push;
   cmd_type     push_cmd;
   logic        pop;
   cmd_type     head;
   logic        queue_full;
   logic        queue_empty;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_count_ff <= 6'd1;
         string_mask_ff <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_FIELD_COUNT: field_count_ff <= csr_if.data[5:0];
            CSR_STRING_MASK: string_mask_ff <= csr_if.data;
            default: begin
            end
         endcase
      end
   end

   // The front end classifies each byte and records what it must emit as a
   // single command entry.
   csvp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_if             (req_if),
      .field_count        (field_count_ff),
      .string_column_mask (string_mask_ff),
      .queue_full         (queue_full),
      .push               (push),
      .push_cmd           (push_cmd)
   );

   // The queue decouples parsing from result issue, so a long zero fill does
   // not stall the byte stream at once.
   csvp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .push_cmd (push_cmd),
      .pop   (pop),
      .head  (head),
      .full  (queue_full),
      .empty (queue_empty)
   );

   // The back end walks each entry: text byte or terminator, field word, then
   // the zero words that complete a short row. The final result of an entry
   // carries last.
   csvp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (queue_empty),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire

// ----- dv/tb_csv_record_field_parser.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CSV record field parser testbench
// Feeds CSV row text into the parser byte by byte and compares every record
// word and string block byte against an in-bench parser built from the spec.
// A short scripted part covers number extremes, quoting rules and register
// corner values. Randomized rows and noise follow under several settings.
// Both channels stall at random.
// ----------------------------------------------------------------------------

module tb_csv_record_field_parser;
   import csvp_pkg::*;

   localparam int          CLK_PERIOD      = 8;
   localparam int          RESET_CYCLES    = 8;
   localparam int          MAX_WAIT        = 12;
   localparam int          DRAIN_CYCLES    = 16;
   localparam int          QUIET_LIMIT     = 2000;
   localparam int          RANDOM_PHASES   = 6;
   localparam int          ITEMS_PER_PHASE = 28;
   localparam int          MAX_PER_BYTE    = 33;
   localparam int          SCRIPT_ROWS     = 25;
   localparam logic [7:0]  CSR_UNUSED      = 8'd2;
   localparam logic [7:0]  CH_LOWER_A      = 8'h61;

   // One transaction on the result channel.
   typedef struct packed {
      logic        kind;
      logic [4:0]  field_index;
      logic [31:0] word_value;
      logic [7:0]  text_byte;
      logic        row_end;
      logic        last;
   } csv_result_type;

   // One transaction on the input channel.
   typedef struct packed {
      logic [7:0] data;
      logic       eod;
   } csv_item_type;

   // A line of the scripted part. When set_cfg is high the registers are
   // rewritten before the text goes out. When typed is high every record
   // word caused by the line must carry the given value.
   typedef struct {
      bit          set_cfg;
      logic [5:0]  fc;
      logic [31:0] mask;
      string       text;
      bit          eod;
      bit          typed;
      logic [31:0] word;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csvp_req_if req_ch ();
   csvp_rsp_if rsp_ch ();
   csvp_csr_if csr_ch ();

   csv_record_field_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Scripted lines. The first group runs at the reset settings, a single
   // field per row, so the expected word can be read straight off the text.
   script_row_type script [SCRIPT_ROWS] = '{
      // Empty line: skipped, no transaction comes out.
      '{1'b0, 6'd0,  32'h0,        "\n",                         1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0,        "0\n",                        1'b0, 1'b1, 32'h0},
      // Largest 64-bit value, then one above it, which overflows to zero.
      '{1'b0, 6'd0,  32'h0,        "18446744073709551615\n",     1'b0, 1'b1, 32'hFFFF_FFFF},
      '{1'b0, 6'd0,  32'h0,        "18446744073709551616\n",     1'b0, 1'b1, 32'h0},
      '{1'b0, 6'd0,  32'h0,        "-18446744073709551615\n",    1'b0, 1'b1, 32'h1},
      '{1'b0, 6'd0,  32'h0,        "4294967296\n",               1'b0, 1'b1, 32'h0},
      '{1'b0, 6'd0,  32'h0,        "-1\n",                       1'b0, 1'b1, 32'hFFFF_FFFF},
      '{1'b0, 6'd0,  32'h0,        " \t+42xyz\n",                1'b0, 1'b1, 32'd42},
      '{1'b0, 6'd0,  32'h0,        "abc\n",                      1'b0, 1'b1, 32'h0},
      // Quoted text in a numeric column; the escaped quote stops the digits.
      '{1'b0, 6'd0,  32'h0,        "\"12\"\"3\"\n",              1'b0, 1'b1, 32'd12},
      // Quote left open until the line end.
      '{1'b0, 6'd0,  32'h0,        "\"7\n",                      1'b0, 1'b1, 32'd7},
      // Fields past the last column are dropped.
      '{1'b0, 6'd0,  32'h0,        "5,6,7\n",                    1'b0, 1'b1, 32'd5},
      // End of data closes an open row, and is harmless with none open.
      '{1'b0, 6'd0,  32'h0,        "9",                          1'b1, 1'b1, 32'd9},
      '{1'b0, 6'd0,  32'h0,        "",                           1'b1, 1'b0, 32'h0},
      // Four columns, columns 1 and 2 hold strings; bit 0 of the mask is set
      // but must not turn column 0 into a string column.
      '{1'b1, 6'd4,  32'h0000_0007, "1,\"ab\",\"\",\"q\"\n",     1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd4,  32'h0000_0007, "\"x\",\"a\"\"b\"c,7\n",     1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd4,  32'h0000_0007, "2,\"open\n",                1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd4,  32'h0000_0007, "3\n",                       1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd4,  32'h0000_0007, "\r\n",                      1'b0, 1'b0, 32'h0},
      // A field count of zero is used as one.
      '{1'b1, 6'd0,  32'hFFFF_FFFF, "\"s\"\n",                   1'b0, 1'b1, 32'h0},
      // A count above the maximum is used as 32: one newline then issues a
      // string terminator, its word and thirty zero fill words.
      '{1'b1, 6'd63, 32'hAAAA_AAAA, ",\"ab\n",                   1'b0, 1'b0, 32'h0},
      // Count shrinks mid-row below the columns already done: no fill.
      '{1'b0, 6'd63, 32'hAAAA_AAAA, "1,2,3",                     1'b0, 1'b0, 32'h0},
      '{1'b1, 6'd2,  32'hAAAA_AAAA, "\n",                        1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd2,  32'hAAAA_AAAA, "4,\"\"\"\"\n",              1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd2,  32'hAAAA_AAAA, "\"\"",                      1'b1, 1'b0, 32'h0}
   };

   // Expected result transactions, oldest first, and the ones that the byte
   // just accepted causes.
   csv_result_type pending_results[$];
   csv_result_type step_out[$];
   csv_item_type   row_q[$];
   int             error_count = 0;

   // Register copies and parse state of the in-bench parser.
   logic [5:0]  cfg_fc;
   logic [31:0] cfg_mask;
   logic [2:0]  fld_phase;
   logic [5:0]  col_idx;
   bit          line_open;
   logic [63:0] acc;
   bit          acc_ovf;
   bit          acc_neg;
   logic [1:0]  scan_phase;
   logic [31:0] block_len;
   logic [31:0] str_offset;
   bit          str_seen;

   // Pacing of both channels. A run is a stretch of transactions that either
   // all go back to back or all draw a random wait.
   int req_hold = 0;
   int req_run = 0;
   bit req_steady = 1'b0;
   bit req_up = 1'b0;
   int rsp_run = 0;
   bit rsp_steady = 1'b0;
   int quiet_cycles = 0;

   function automatic int draw_wait(inout int run_left, inout bit steady);
      if (run_left == 0) begin
         run_left = $urandom_range(8, 40);
         steady   = ($urandom_range(0, 2) == 0);
      end
      run_left--;
      return steady ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // ------------------------------------------------------------------------
   // In-bench parser
   // ------------------------------------------------------------------------

   // Field count as the block uses it: zero counts as one, and anything over
   // the column limit is cut to the limit.
   function automatic int active_fields();
      if (cfg_fc == 6'd0) return 1;
      if (int'(cfg_fc) > MAX_FIELDS) return MAX_FIELDS;
      return int'(cfg_fc);
   endfunction

   task automatic emit_result(input logic k, input logic [5:0] col, input logic [31:0] w,
                              input logic [7:0] t, input logic re);
      csv_result_type r;
      if (step_out.size() >= MAX_PER_BYTE) return;
      r.kind        = k;
      r.field_index = col[4:0];
      r.word_value  = w;
      r.text_byte   = t;
      r.row_end     = re;
      r.last        = 1'b0;
      step_out.insert(step_out.size(), r);
   endtask

   task automatic clear_field();
      fld_phase  = PH_START;
      acc        = '0;
      acc_ovf    = 1'b0;
      acc_neg    = 1'b0;
      scan_phase = NP_WS;
      str_offset = '0;
      str_seen   = 1'b0;
   endtask

   // State after reset or end of data. The string block restarts at offset 1
   // because offset 0 is the implicit empty string.
   task automatic restart_parse();
      clear_field();
      col_idx   = '0;
      line_open = 1'b0;
      block_len = 32'd1;
   endtask

   // One byte of a base-10 strtoul scan on a 64-bit accumulator.
   task automatic scan_number(input logic [7:0] b);
      bit          digit;
      bit          space;
      logic [63:0] d;
      digit = (b >= CH_ZERO) && (b <= CH_NINE);
      space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
      d     = {56'd0, b - CH_ZERO};
      if (scan_phase == NP_WS) begin
         if (space) return;
         if ((b == CH_PLUS) || (b == CH_MINUS)) begin
            acc_neg    = (b == CH_MINUS);
            scan_phase = NP_SIGN;
            return;
         end
         scan_phase = digit ? NP_DIGITS : NP_DONE;
      end else if (scan_phase == NP_SIGN) begin
         scan_phase = digit ? NP_DIGITS : NP_DONE;
      end else if ((scan_phase == NP_DIGITS) && !digit) begin
         scan_phase = NP_DONE;
      end
      if ((scan_phase == NP_DIGITS) && !acc_ovf) begin
         if ((acc > ACC_LIMIT) || ((acc == ACC_LIMIT) && (d > 64'd5))) begin
            acc_ovf = 1'b1;
         end else begin
            acc = acc * 64'd10 + d;
         end
      end
   endtask

   task automatic store_text(input logic [7:0] b);
      if (!str_seen) begin
         str_seen   = 1'b1;
         str_offset = block_len;
      end
      emit_result(1'b1, col_idx, 32'h0, b, 1'b0);
      block_len = block_len + 32'd1;
   endtask

   task automatic close_field();
      logic [31:0] v;
      logic [63:0] a;
      if ((fld_phase == PH_STR) || (fld_phase == PH_STR_Q)) begin
         if (str_seen) begin
            emit_result(1'b1, col_idx, 32'h0, 8'h00, 1'b0);
            block_len = block_len + 32'd1;
            v = str_offset;
         end else begin
            v = 32'h0;
         end
      end else if (acc_ovf) begin
         v = 32'h0;
      end else begin
         a = acc_neg ? (64'd0 - acc) : acc;
         v = a[31:0];
      end
      emit_result(1'b0, col_idx, v, 8'h00, (int'(col_idx) + 1 == active_fields()));
      col_idx = col_idx + 6'd1;
      clear_field();
   endtask

   task automatic open_field(input logic [7:0] b);
      if (int'(col_idx) >= active_fields()) return;
      if (b == CH_QUOTE) begin
         fld_phase = ((col_idx != 6'd0) && (col_idx < 6'd32) && cfg_mask[col_idx[4:0]]) ?
                     PH_STR : PH_QNUM;
      end else if (b == CH_COMMA) begin
         close_field();
      end else begin
         fld_phase = PH_NUM;
         scan_number(b);
      end
   endtask

   // Line end: close the open field, then zero-fill the rest of the row.
   task automatic close_row();
      int cnt;
      cnt = active_fields();
      if (line_open) begin
         if ((fld_phase != PH_START) && (int'(col_idx) < cnt)) close_field();
         while (int'(col_idx) < cnt) begin
            emit_result(1'b0, col_idx, 32'h0, 8'h00, (int'(col_idx) + 1 == cnt));
            col_idx = col_idx + 6'd1;
         end
      end
      clear_field();
      col_idx   = '0;
      line_open = 1'b0;
   endtask

   // Works out every result transaction that one input transaction causes.
   task automatic parse_csv_byte(input logic [7:0] b, input logic eod);
      step_out.delete();
      if (eod) begin
         close_row();
         restart_parse();
      end else if (b == CH_NEWLINE) begin
         close_row();
      end else begin
         line_open = 1'b1;
         case (fld_phase)
            PH_NUM: begin
               if (b == CH_COMMA) close_field();
               else scan_number(b);
            end
            PH_QNUM: begin
               if (b == CH_QUOTE) fld_phase = PH_QNUM_Q;
               else scan_number(b);
            end
            PH_QNUM_Q: begin
               // A second quote is an escaped quote, which the number scan
               // sees as an ordinary character.
               if (b == CH_QUOTE) begin
                  scan_number(CH_QUOTE);
                  fld_phase = PH_QNUM;
               end else begin
                  close_field();
                  if (b != CH_COMMA) open_field(b);
               end
            end
            PH_STR: begin
               if (b == CH_QUOTE) fld_phase = PH_STR_Q;
               else store_text(b);
            end
            PH_STR_Q: begin
               if (b == CH_QUOTE) begin
                  store_text(CH_QUOTE);
                  fld_phase = PH_STR;
               end else begin
                  // A comma right after the closing quote is consumed; any
                  // other byte opens the next field.
                  close_field();
                  if (b != CH_COMMA) open_field(b);
               end
            end
            default: begin
               fld_phase = PH_START;
               open_field(b);
            end
         endcase
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------------

   // Sends one byte. Valid stays high into the next transaction when the
   // next wait is zero, so it is never lowered and raised in one time step.
   task automatic send_item(input logic [7:0] b, input logic eod, input bit typed,
                            input logic [31:0] typed_word);
      csv_result_type r;
      repeat (req_hold) @(posedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.end_of_data <= eod;
      req_up = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      parse_csv_byte(b, eod);
      foreach (step_out[i]) begin
         r = step_out[i];
         if (typed && (r.kind == 1'b0)) r.word_value = typed_word;
         pending_results.insert(pending_results.size(), r);
      end
      req_hold = draw_wait(req_run, req_steady);
      if (req_hold > 0) begin
         req_ch.valid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   // Lowers the input channel and lets the block drain. A byte that causes
   // nothing may still be in flight when the last result arrives, hence the
   // extra cycles.
   task automatic settle();
      if (req_up) begin
         req_ch.valid <= 1'b0;
         req_up = 1'b0;
      end
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [7:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_FIELD_COUNT: cfg_fc = val[5:0];
         CSR_STRING_MASK: cfg_mask = val;
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Random row text
   // ------------------------------------------------------------------------

   task automatic put_byte(input logic [7:0] b);
      row_q.insert(row_q.size(), csv_item_type'{data: b, eod: 1'b0});
   endtask

   // Unquoted number: optional blank and sign, a digit run that is short,
   // long, or right at the 64-bit limit, and now and then trailing letters.
   task automatic gen_number();
      string limit_digits = "1844674407370955161";
      int    n;
      if ($urandom_range(0, 5) == 0) put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      if ($urandom_range(0, 3) == 0) put_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      case ($urandom_range(0, 7))
         0: n = 0;
         5: n = 10;
         6: n = $urandom_range(19, 22);
         7: n = -1;
         default: n = $urandom_range(1, 4);
      endcase
      if (n < 0) begin
         for (int i = 0; i < limit_digits.len(); i++) put_byte(limit_digits[i]);
         put_byte(CH_ZERO + 8'($urandom_range(4, 7)));
      end else begin
         for (int i = 0; i < n; i++) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 7) == 0) put_byte(CH_LOWER_A + 8'($urandom_range(0, 25)));
   endtask

   // Quoted field with escaped quotes, some high bytes, sometimes no closing
   // quote and sometimes a stray byte after it.
   task automatic gen_quoted();
      int         len;
      logic [7:0] c;
      put_byte(CH_QUOTE);
      len = $urandom_range(0, 6);
      repeat (len) begin
         c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255)) :
                                           8'($urandom_range(32, 126));
         if ((c == CH_QUOTE) || ($urandom_range(0, 7) == 0)) begin
            put_byte(CH_QUOTE);
            put_byte(CH_QUOTE);
         end else begin
            put_byte(c);
         end
      end
      if ($urandom_range(0, 7) != 0) begin
         put_byte(CH_QUOTE);
         if ($urandom_range(0, 5) == 0) put_byte(8'($urandom_range(32, 126)));
      end
   endtask

   // A well-formed row, with the column count sometimes short or too long,
   // ended by a newline, by end of data, or running on into the next row.
   task automatic gen_row();
      int nf;
      int pick;
      bit text_col;
      nf = $urandom_range(0, active_fields() + 1);
      for (int c = 0; c < nf; c++) begin
         if (c > 0) put_byte(CH_COMMA);
         text_col = (c > 0) && (c < 32) && cfg_mask[c & 31];
         pick = $urandom_range(0, 9);
         if (text_col ? (pick < 6) : (pick < 2)) gen_quoted();
         else if (pick < 9) gen_number();
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         row_q.insert(row_q.size(),
                      csv_item_type'{data: 8'($urandom_range(0, 255)), eod: 1'b1});
      end else if (pick != 1) begin
         put_byte(CH_NEWLINE);
      end
   endtask

   task automatic gen_noise();
      repeat ($urandom_range(1, 10)) begin
         row_q.insert(row_q.size(), csv_item_type'{data: 8'($urandom_range(0, 255)),
                                                   eod: ($urandom_range(0, 15) == 0)});
      end
   endtask

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   task automatic flag_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
   endtask

   // Every accepted result transaction is compared with the oldest one
   // expected. Values are sampled at the edge, before any update lands.
   always @(posedge clock) begin : check_results
      csv_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual kind %0d",
                     $time, rsp_ch.kind, " index %0d word 0x%0h text 0x%0h",
                     rsp_ch.field_index, rsp_ch.word_value, rsp_ch.text_byte);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.kind !== want.kind)
               flag_field("kind", want.kind, rsp_ch.kind);
            if (rsp_ch.field_index !== want.field_index)
               flag_field("field_index", want.field_index, rsp_ch.field_index);
            if (rsp_ch.word_value !== want.word_value)
               flag_field("word_value", want.word_value, rsp_ch.word_value);
            if (rsp_ch.text_byte !== want.text_byte)
               flag_field("text_byte", want.text_byte, rsp_ch.text_byte);
            if (rsp_ch.row_end !== want.row_end)
               flag_field("row_end", want.row_end, rsp_ch.row_end);
            if (rsp_ch.last !== want.last)
               flag_field("last", want.last, rsp_ch.last);
         end
      end
   end

   // The result side draws a stall for every transaction. Ready stays high
   // when the draw is zero.
   initial begin : rsp_pacing
      int hold;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         hold = draw_wait(rsp_run, rsp_steady);
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Watchdog: the run is stuck if no channel moves a transaction for a long
   // stretch. The limit is far above the longest quiet time of a good run.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   initial begin : stimulus
      int          sent;
      logic [5:0]  fc_val;
      logic [31:0] mask_val;
      logic [31:0] fc_word;

      req_ch.valid       <= 1'b0;
      req_ch.data_byte   <= 8'h00;
      req_ch.end_of_data <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= CSR_FIELD_COUNT;
      csr_ch.data        <= 32'h0;
      cfg_fc   = 6'd1;
      cfg_mask = 32'h0;
      restart_parse();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Scripted part. Registers are only rewritten once the block is idle,
      // which may still be in the middle of a row.
      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         if (script[r].set_cfg) begin
            settle();
            write_csr(CSR_FIELD_COUNT, {26'd0, script[r].fc});
            write_csr(CSR_STRING_MASK, script[r].mask);
         end
         for (int i = 0; i < script[r].text.len(); i++)
            send_item(script[r].text[i], 1'b0, script[r].typed, script[r].word);
         if (script[r].eod)
            send_item(8'($urandom_range(0, 255)), 1'b1, script[r].typed, script[r].word);
      end

      // Random part: each phase picks a setting, extremes included, and then
      // streams mostly well-formed rows with some raw noise in between. A
      // phase stops at its byte budget, even in the middle of a row.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         mask_val = $urandom();
         case (ph)
            0: fc_val = 6'd2;
            1: begin
               fc_val   = 6'd32;
               mask_val = 32'hFFFF_FFFF;
            end
            2: begin
               fc_val   = 6'd0;
               mask_val = 32'h0;
            end
            3: fc_val = 6'd63;
            4: fc_val = 6'($urandom_range(1, 8));
            default: fc_val = 6'($urandom_range(0, 63));
         endcase
         // Upper bits of the count write are junk the block must drop.
         fc_word = $urandom();
         fc_word[5:0] = fc_val;
         write_csr(CSR_FIELD_COUNT, fc_word);
         write_csr(CSR_STRING_MASK, mask_val);
         if (ph == 0) write_csr(CSR_UNUSED, $urandom());
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            row_q.delete();
            if ($urandom_range(0, 9) == 0) gen_noise();
            else gen_row();
            foreach (row_q[i]) begin
               if (sent < ITEMS_PER_PHASE) begin
                  send_item(row_q[i].data, row_q[i].eod, 1'b0, 32'h0);
                  sent++;
               end
            end
         end
      end

      settle();
      if ((error_count == 0) && (pending_results.size() == 0)) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
